### rtl/utf8_stream_decoder_defines.svh
// assertion macros shared by the utf8 stream decoder rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define UTF8SD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define UTF8SD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/utf8sd_pkg.sv
// types and constants for the utf8 stream decoder
// no dependencies
`default_nettype none

package utf8sd_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned CpW       = 21;
    localparam int unsigned LenW      = 3;
    localparam int unsigned MaxResults = 4;
    localparam int unsigned CntW      = $clog2(MaxResults + 1);

    // byte class masks and patterns
    localparam logic [ByteW-1:0] ContMask  = 8'hC0;
    localparam logic [ByteW-1:0] ContPat   = 8'h80;
    localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
    localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
    localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
    localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
    localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
    localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;
    localparam logic [ByteW-1:0] AsciiMask = 8'h80;
    localparam logic [ByteW-1:0] EndByte   = 8'h00;

    // continuations an open sequence needs in total, set from its lead byte
    localparam logic [1:0] NeedNone  = 2'd0;
    localparam logic [1:0] NeedOne   = 2'd1;
    localparam logic [1:0] NeedTwo   = 2'd2;
    localparam logic [1:0] NeedThree = 2'd3;

    localparam logic [LenW-1:0] LenSingle = 3'd1;

    typedef struct packed {
        logic [CpW-1:0]  cp;
        logic [LenW-1:0] len;
        logic            last;
    } result_t;

endpackage

`default_nettype wire

### rtl/utf8_stream_decoder.sv
// a byte's beat is registered in the input register, then decoded into the result list on the output
// throughput: one byte per cycle while each byte yields at most one result and cp_stall is low
// a broken sequence drains up to four results and end of text up to three, one per cycle while
// cp_stall is low, holding off input meanwhile; the result list register sets this figure
// reset: asynchronous active-low, clears the open sequence and all valid flags
`default_nettype none

`include "utf8_stream_decoder_defines.svh"

module utf8_stream_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         byte_valid,
    output logic                              byte_stall,
    input  wire logic [utf8sd_pkg::ByteW-1:0] text_byte,
    output logic                              cp_valid,
    input  wire logic                         cp_stall,
    output logic [utf8sd_pkg::CpW-1:0]        code_point,
    output logic [utf8sd_pkg::LenW-1:0]       seq_length,
    output logic                              last_of_run
);
    import utf8sd_pkg::*;

    // input register
    logic             in_vld_reg, in_vld_next;
    logic [ByteW-1:0] in_byte_reg;

    // open sequence
    logic [ByteW-1:0] held_lead_reg, held_lead_next;
    logic [ByteW-1:0] held_cont_reg [2];
    logic [1:0]       held_count_reg, held_count_next;
    logic [1:0]       needed_reg, needed_next;
    logic             cont_wr;
    logic             cont_idx;
    logic             seq_open;

    // result list, entry 0 is on the output
    result_t          res_reg [MaxResults];
    result_t          res_next [MaxResults];
    logic [CntW-1:0]  res_cnt_reg, res_cnt_next;

    logic             in_take, out_take, list_free, fire;
    result_t          dec_res [MaxResults];
    logic [CntW-1:0]  dec_cnt;

    assign out_take  = cp_valid && !cp_stall;
    assign list_free = (res_cnt_reg == '0) || (res_cnt_reg == CntW'(1) && out_take);
    assign fire      = in_vld_reg && list_free;
    assign byte_stall = in_vld_reg && !list_free;
    assign in_take   = byte_valid && !byte_stall;
    assign seq_open  = (held_count_reg != 2'd0);

    assign cp_valid    = (res_cnt_reg != '0);
    assign code_point  = res_reg[0].cp;
    assign seq_length  = res_reg[0].len;
    assign last_of_run = res_reg[0].last;

    // decode one byte against the open sequence
    always_comb
    begin
        logic [ByteW-1:0] b;
        logic [1:0]       conts;
        logic [CntW-1:0]  n;
        logic             raw;
        b     = in_byte_reg;
        conts = held_count_reg - 2'd1;
        n     = '0;
        raw   = 1'b0;
        held_lead_next  = held_lead_reg;
        held_count_next = held_count_reg;
        needed_next     = needed_reg;
        cont_wr  = 1'b0;
        cont_idx = conts[0];
        for (int k = 0; k < MaxResults; k++)
        begin
            dec_res[k] = '{cp: '0, len: LenSingle, last: 1'b0};
        end

        if (held_count_reg != 2'd0 && (b & ContMask) == ContPat)
        begin
            if ({1'b0, conts} + 3'd1 >= {1'b0, needed_reg})
            begin
                unique case (needed_reg)
                    NeedOne:
                        dec_res[0].cp = CpW'({held_lead_reg[4:0], b[5:0]});
                    NeedTwo:
                        dec_res[0].cp = CpW'({held_lead_reg[3:0], held_cont_reg[0][5:0],
                                              b[5:0]});
                    default:
                        dec_res[0].cp = CpW'({held_lead_reg[2:0], held_cont_reg[0][5:0],
                                              held_cont_reg[1][5:0], b[5:0]});
                endcase
                dec_res[0].len  = {1'b0, needed_reg} + LenW'(1);
                n = CntW'(1);
                held_lead_next  = '0;
                held_count_next = 2'd0;
                needed_next     = NeedNone;
            end
            else
            begin
                cont_wr         = 1'b1;
                held_count_next = held_count_reg + 2'd1;
            end
        end
        else
        begin
            // broken sequence: lead, then each held continuation, as single bytes
            if (held_count_reg != 2'd0)
            begin
                dec_res[0].cp = CpW'(held_lead_reg);
                dec_res[1].cp = CpW'(held_cont_reg[0]);
                dec_res[2].cp = CpW'(held_cont_reg[1]);
                n = CntW'(held_count_reg);
                held_lead_next  = '0;
                held_count_next = 2'd0;
                needed_next     = NeedNone;
            end
            if (b == EndByte)
            begin
                raw = 1'b0;
            end
            else if ((b & AsciiMask) == '0)
            begin
                raw = 1'b1;
            end
            else if ((b & Lead2Mask) == Lead2Pat)
            begin
                held_lead_next = b; held_count_next = 2'd1; needed_next = NeedOne;
            end
            else if ((b & Lead3Mask) == Lead3Pat)
            begin
                held_lead_next = b; held_count_next = 2'd1; needed_next = NeedTwo;
            end
            else if ((b & Lead4Mask) == Lead4Pat)
            begin
                held_lead_next = b; held_count_next = 2'd1; needed_next = NeedThree;
            end
            else
            begin
                raw = 1'b1;
            end
            if (raw)
            begin
                dec_res[n[1:0]].cp = CpW'(b);
                n = n + CntW'(1);
            end
        end

        if (n != '0)
        begin
            dec_res[n[1:0] - 2'd1].last = 1'b1;
        end
        dec_cnt = n;
    end

    // result list: load on decode, otherwise shift down as beats leave
    always_comb
    begin
        res_next     = res_reg;
        res_cnt_next = res_cnt_reg;
        if (fire)
        begin
            res_next     = dec_res;
            res_cnt_next = dec_cnt;
        end
        else if (out_take)
        begin
            for (int k = 0; k < MaxResults - 1; k++)
            begin
                res_next[k] = res_reg[k+1];
            end
            res_cnt_next = res_cnt_reg - CntW'(1);
        end
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (fire)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            res_cnt_reg    <= '0;
            held_lead_reg  <= '0;
            held_count_reg <= 2'd0;
            needed_reg     <= NeedNone;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            res_cnt_reg <= res_cnt_next;
            if (fire)
            begin
                held_lead_reg  <= held_lead_next;
                held_count_reg <= held_count_next;
                needed_reg     <= needed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= text_byte;
        end
        if (fire && cont_wr)
        begin
            held_cont_reg[cont_idx] <= in_byte_reg;
        end
        res_reg <= res_next;
    end

    `UTF8SD_ASSERT_ALWAYS(a_cnt_range, res_cnt_reg <= CntW'(MaxResults), "result count overflow")
    `UTF8SD_ASSERT_IMPL(a_open_seq, seq_open, held_count_reg <= needed_reg, "sequence overfull")
    `UTF8SD_ASSERT_IMPL(a_last_tail, res_cnt_reg == CntW'(1), last_of_run, "tail not last")
    `UTF8SD_ASSERT_IMPL(a_stall_busy, byte_stall, res_cnt_reg != '0 && in_vld_reg, "idle stall")

endmodule

`default_nettype wire
